>>> rtl/stable_priority_queue_macros.svh
// Assertion macros for the checker file of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int PRIO_W    = 8;
    localparam int DATA_W    = 8;
    localparam int OCC_W     = 5;

    // Operation codes of the func field.
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] priority_req;
        logic [DATA_W-1:0] data_in;
    } spq_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              data_valid;
        logic [1:0]        status;
        logic [OCC_W-1:0]  occupancy;
    } spq_rsp_t;

    // One stored entry of the queue.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } spq_entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              shift_in;
        logic              shift_out;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } spq_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
`default_nettype none

// One slot of the sorted chain. It holds an entry and decides from its own
// contents and its left neighbor's decision whether to keep, insert or shift.
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic               clk,
    input  wire spq_pkg::spq_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]   count,
    input  wire spq_pkg::spq_entry_t left_entry,
    input  wire logic               left_take,
    input  wire spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t     entry,
    output logic                    take
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       occupied;

    // A slot is occupied when its index lies below the fill count. The new
    // entry belongs in this slot or before it when the slot is empty or
    // holds a strictly larger priority; the queue is sorted, so this flag
    // rises once along the chain and stays high.
    assign occupied = CNT_W'(IDX) < count;
    assign take     = !occupied || (entry_reg.prio > ctrl.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_in && take)
        begin
            if (left_take)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.prio = ctrl.prio;
                entry_next.data = ctrl.data;
            end
        end
        else if (ctrl.shift_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> rtl/stable_priority_queue.sv
// Channel  Direction  Payload    Handshake
// req      in         spq_req_t  req_valid / req_stall
// rsp      out        spq_rsp_t  rsp_valid / rsp_stall
//
// Every cell of the chain compares its priority with the new one in
// parallel and loads, shifts or keeps its entry at the same edge, so one
// item per cycle is sustained while req_stall stays low.
// The result item sits in a single output register; req_stall rises only
// while that register holds a result that the consumer is stalling.
// Reset clears the fill count and the output valid flag; slot contents are
// left as they are and are never read before they are written.
`default_nettype none

module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire spq_pkg::spq_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output spq_pkg::spq_rsp_t      rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    logic       accept;
    logic       full;
    logic       empty;
    spq_ctrl_t  ctrl;

    spq_entry_t       cell_entry [DEPTH];
    spq_entry_t       left_entry [DEPTH];
    spq_entry_t       right_entry[DEPTH];
    logic [DEPTH-1:0] cell_take;
    logic [DEPTH-1:0] left_take;

    // A new item is taken unless a finished result is still being stalled.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;

    // The command for the chain only fires for operations that change state:
    // an enqueue into a full queue and a dequeue from an empty one are no-ops.
    always_comb
    begin
        ctrl.shift_in  = accept && (req.func == FUNC_ENQ) && !full;
        ctrl.shift_out = accept && (req.func == FUNC_DEQ) && !empty;
        ctrl.prio      = req.priority_req;
        ctrl.data      = req.data_in;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.shift_in)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.shift_out)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // The result carries the head entry on a dequeue and the occupancy that
    // the item leaves behind.
    always_comb
    begin
        rsp_next            = '0;
        rsp_next.occupancy  = OCC_W'(count_next);
        if (req.func == FUNC_ENQ)
        begin
            rsp_next.status = full ? ST_FULL : ST_OK;
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.status     = ST_OK;
            rsp_next.data_valid = 1'b1;
            rsp_next.data_out   = cell_entry[0].data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The chain of cells. The head cell sees no insertion to its left, and
    // the tail cell refills from itself on a dequeue; that copy lies beyond
    // the fill count and is never read.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_entry[i] = '0;
            assign left_take[i]  = 1'b0;
        end
        else
        begin : g_body
            assign left_entry[i] = cell_entry[i-1];
            assign left_take[i]  = cell_take[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry[i] = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry[i] = cell_entry[i+1];
        end

        spq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (left_entry[i]),
            .left_take   (left_take[i]),
            .right_entry (right_entry[i]),
            .entry       (cell_entry[i]),
            .take        (cell_take[i])
        );
    end

endmodule

`default_nettype wire

>>> rtl/spq_checker.sv
`default_nettype none
`include "stable_priority_queue_macros.svh"

module spq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    logic rsp_held;
    logic req_taken;
    logic rsp_failed;
    logic rsp_clean;
    logic rsp_empty;

    assign rsp_held   = rsp_valid && rsp_stall;
    assign req_taken  = req_valid && !req_stall;
    assign rsp_failed = rsp_valid && (rsp.status != ST_OK);
    assign rsp_clean  = !rsp.data_valid && (rsp.data_out == '0);
    assign rsp_empty  = rsp_valid && (rsp.status == ST_EMPTY);

    `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_held, rsp_valid && $stable(rsp), "held item moved")
    `SPQ_ASSERT_NOW(a_no_overrun, clk, rst_n, rsp_held, req_stall, "input not stalled")
    `SPQ_ASSERT_NOW(a_data_ok, clk, rst_n, rsp_failed, rsp_clean, "failed item carries data")
    `SPQ_ASSERT_NOW(a_empty_occ, clk, rst_n, rsp_empty, rsp.occupancy == '0, "occupancy on empty")
    `SPQ_ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_taken, rsp_valid, "no result for item")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

>>> sim/tb_stable_priority_queue.sv
module tb_stable_priority_queue;

    import spq_pkg::*;

    // A run of this many cycles with neither channel moving an item means the
    // block has hung. The longest legal quiet spell is a long sender gap that
    // overlaps a long consumer stall, both well under this limit.
    localparam int IDLE_LIMIT = 2000;

    // Items in the random part, on top of the directed table.
    localparam int RANDOM_ITEMS = 1625;

    // Number of rows in the directed table below.
    localparam int NUM_ROWS = 25;

    // How the random part spreads priorities within a phase. A crowded
    // spread packs many entries onto a few values, which exercises the
    // first-in first-out order among equal priorities.
    typedef enum int {
        PRIO_ANY,
        PRIO_CROWDED,
        PRIO_EXTREME
    } prio_spread_e;

    // One row of the directed table. When fixed is set, the expected result
    // is typed in here. Otherwise the queue predictor supplies it.
    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
        logic              fixed;
        logic [DATA_W-1:0] x_data;
        logic              x_valid;
        logic [1:0]        x_status;
        logic [OCC_W-1:0]  x_occ;
    } dir_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    spq_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    spq_rsp_t rsp;

    // These travel with each request item, so that the monitor can tell at
    // the accepting edge whether a typed-in result applies to that item.
    logic     golden_on  = 1'b0;
    spq_rsp_t golden_rsp = '0;

    // The predictor's own copy of the queue: priorities and data kept sorted
    // by ascending priority, and the number of live slots.
    logic [PRIO_W-1:0] model_prio [SPQ_DEPTH];
    logic [DATA_W-1:0] model_data [SPQ_DEPTH];
    int                model_fill = 0;

    // Results still owed by the block, oldest first.
    spq_rsp_t pending_results [$];

    int error_count = 0;
    int idle_cycles = 0;

    // Consumer stall pattern: alternate calm spells and stall spells.
    int stall_left = 0;
    int calm_left  = 0;

    // Directed table. It opens with a dequeue on an empty queue straight out
    // of reset, checks the two priority extremes and a tie at priority zero,
    // drains the queue to empty again, then fills all sixteen slots with a
    // walking-bit data pattern and duplicate priorities, and finally pushes
    // one more entry into the full queue, which must be dropped.
    dir_row_t directed_rows [NUM_ROWS] = '{
        '{FUNC_DEQ, 8'd0,   8'h00, 1'b1, 8'h00, 1'b0, ST_EMPTY, 5'd0},
        '{FUNC_ENQ, 8'd255, 8'hFF, 1'b1, 8'h00, 1'b0, ST_OK,    5'd1},
        '{FUNC_ENQ, 8'd0,   8'h00, 1'b1, 8'h00, 1'b0, ST_OK,    5'd2},
        '{FUNC_ENQ, 8'd0,   8'h5A, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_DEQ, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_DEQ, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_DEQ, 8'd0,   8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_DEQ, 8'd0,   8'h00, 1'b1, 8'h00, 1'b0, ST_EMPTY, 5'd0},
        '{FUNC_ENQ, 8'd128, 8'h01, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd64,  8'h02, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd128, 8'h04, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd200, 8'h08, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd0,   8'h10, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd255, 8'h20, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd64,  8'h40, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd128, 8'h80, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd1,   8'hFE, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd254, 8'hFD, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd64,  8'hFB, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd7,   8'hF7, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd128, 8'hEF, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd0,   8'hDF, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd255, 8'hBF, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd100, 8'h7F, 1'b0, 8'h00, 1'b0, ST_OK,    5'd0},
        '{FUNC_ENQ, 8'd42,  8'hAA, 1'b1, 8'h00, 1'b0, ST_FULL,  5'd16}
    };

    stable_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Applies one request item to the predictor's queue and returns the
    // result item that the block must give for it. A new entry goes behind
    // every stored entry with a lower or equal priority, so equal priorities
    // leave in arrival order. A full queue drops the entry, and an empty
    // queue answers a dequeue with zero data.
    function automatic spq_rsp_t predict_queue_result(spq_req_t op);
        spq_rsp_t res;
        int       pos;
        res = '0;
        if (op.func == FUNC_ENQ) begin
            if (model_fill >= SPQ_DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < model_fill && model_prio[pos] <= op.priority_req) begin
                    pos++;
                end
                for (int k = model_fill; k > pos; k--) begin
                    model_prio[k] = model_prio[k - 1];
                    model_data[k] = model_data[k - 1];
                end
                model_prio[pos] = op.priority_req;
                model_data[pos] = op.data_in;
                model_fill++;
                res.status = ST_OK;
            end
        end
        else if (model_fill == 0) begin
            res.status = ST_EMPTY;
        end
        else begin
            res.data_out   = model_data[0];
            res.data_valid = 1'b1;
            res.status     = ST_OK;
            for (int k = 1; k < model_fill; k++) begin
                model_prio[k - 1] = model_prio[k];
                model_data[k - 1] = model_data[k];
            end
            model_fill--;
        end
        res.occupancy = OCC_W'(model_fill);
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Sender gap length: mostly back to back, sometimes a short gap, and
    // now and then a long pause. A phase without gaps always sends at once.
    function automatic int pick_gap(bit gappy);
        int roll;
        roll = $urandom_range(0, 99);
        if (!gappy || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Presents one request item and holds it until the block takes it. With
    // no gap the valid simply stays high for the next item, so it is never
    // lowered and raised within the same time step.
    task automatic send_op(input spq_req_t op, input logic fixed, input spq_rsp_t golden,
                           input int gap);
        req        <= op;
        golden_on  <= fixed;
        golden_rsp <= golden;
        req_valid  <= 1'b1;
        do begin
            @(posedge clk);
        end while (req_stall);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every owed result has come back. Each item
    // causes exactly one result, so an empty store means the block is idle.
    // The first edge lets the monitor record an item accepted at the edge
    // this task was called on.
    task automatic wait_for_results;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Consumer side. The stall pattern mixes calm spells of varied length,
    // including long ones with no stall at all, with stall spells that are
    // mostly short and occasionally long enough to back the block
    // up into the request channel.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
        end
        else begin
            calm_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 3);
            rsp_stall <= 1'b0;
        end
    end

    // Monitor. Values read here are the ones that stood before the edge, so
    // the handshake seen is the one the block saw. The expectation for a
    // newly accepted request goes into the store before the result check,
    // which keeps the order right whatever the block's latency is.
    always @(posedge clk) begin : monitor_blk
        spq_rsp_t predicted;
        spq_rsp_t want;
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                predicted = predict_queue_result(req);
                pending_results.push_back(golden_on ? golden_rsp : predicted);
            end
            if (rsp_valid && !rsp_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no request outstanding: %p", rsp);
                    error_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("data_out", want.data_out, rsp.data_out);
                    check_field("data_valid", want.data_valid, rsp.data_valid);
                    check_field("status", want.status, rsp.status);
                    check_field("occupancy", want.occupancy, rsp.occupancy);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        spq_req_t     op;
        spq_rsp_t     golden;
        prio_spread_e spread;
        int           items_left;
        int           phase_len;
        int           enq_pct;
        bit           gappy;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table with random gaps on the sender.
        foreach (directed_rows[i]) begin
            op.func         = directed_rows[i].func;
            op.priority_req = directed_rows[i].prio;
            op.data_in      = directed_rows[i].data;
            golden.data_out   = directed_rows[i].x_data;
            golden.data_valid = directed_rows[i].x_valid;
            golden.status     = directed_rows[i].x_status;
            golden.occupancy  = directed_rows[i].x_occ;
            send_op(op, directed_rows[i].fixed, golden, pick_gap(1'b1));
        end

        // Let the block settle with a full queue before the random part.
        wait_for_results();

        // Random part, in phases. Most phases lean toward enqueue or toward
        // dequeue, so the queue swings between full and empty and spends
        // time at both edges, where drops and empty dequeues happen. The
        // priority spread and the sender's gap pattern change per phase.
        items_left = RANDOM_ITEMS;
        while (items_left > 0) begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 4))
                0: enq_pct = 92;
                1: enq_pct = 70;
                2: enq_pct = 50;
                3: enq_pct = 30;
                default: enq_pct = 8;
            endcase
            spread = prio_spread_e'($urandom_range(0, 2));
            gappy  = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < phase_len && items_left > 0; n++) begin
                op.func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                case (spread)
                    PRIO_CROWDED: op.priority_req = PRIO_W'($urandom_range(0, 3));
                    PRIO_EXTREME: op.priority_req = ($urandom_range(0, 1) != 0) ? 8'hFF
                                                                               : 8'h00;
                    default:      op.priority_req = PRIO_W'($urandom_range(0, 255));
                endcase
                op.data_in = DATA_W'($urandom_range(0, 255));
                send_op(op, 1'b0, '0, pick_gap(gappy));
                items_left--;
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_results();
            end
        end

        // Wind down: collect every owed result, then give anything stray a
        // chance to show up before the verdict.
        wait_for_results();
        repeat (4) @(posedge clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
sim/tb_stable_priority_queue.sv
